@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// Every macro expects clk in scope; all but ASSERT_NEXT_ALWAYS use active-low rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tacs_pkg.sv @@
// Shared types, codes, constants and helper functions of the two-axis command sequencer.
`timescale 1ns / 1ps

package tacs_pkg;

  // Command ring: holds at most QUEUE_SLOTS-1 commands.
  localparam int QUEUE_SLOTS = 8;
  localparam int Q_IDX_W     = $clog2(QUEUE_SLOTS);
  localparam int Q_CNT_W     = $clog2(QUEUE_SLOTS + 1);

  // Queue between the front and the back end.
  localparam int FQ_SLOTS = 2;
  localparam int FQ_IDX_W = (FQ_SLOTS > 1) ? $clog2(FQ_SLOTS) : 1;
  localparam int FQ_CNT_W = $clog2(FQ_SLOTS + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_GAP      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AXIS_GAP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_INVERT    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_INVERT   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_AXIS_ON   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_AXIS_ON  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EN_ACT_HIGH   = 4'd7;

  localparam logic [14:0] RST_MAX_RPM      = 15'd3000;
  localparam logic [15:0] RST_AXIS_GAP     = 16'd5;
  localparam logic [15:0] RST_MIN_AXIS_GAP = 16'd1;

  // Request codes.
  localparam logic [1:0] ACT_POLL = 2'd0;
  localparam logic [1:0] ACT_VEL  = 2'd1;
  localparam logic [1:0] ACT_EN   = 2'd2;
  localparam logic [1:0] ACT_STOP = 2'd3;

  // Command and result kinds.
  localparam logic [1:0] KIND_VEL  = 2'd0;
  localparam logic [1:0] KIND_EN   = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic AXIS_PAN  = 1'b0;
  localparam logic AXIS_TILT = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        now_ms;
    logic signed [15:0] pan_speed;
    logic signed [15:0] tilt_speed;
    logic               enable_request;
  } in_item_t;

  typedef struct packed {
    logic        axis;
    logic [1:0]  kind;
    logic        direction;
    logic [14:0] speed_magnitude;
    logic        enable_level;
    logic [2:0]  queue_depth;
    logic [31:0] drops;
  } out_item_t;

  // One stored command.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pan;
    logic signed [15:0] tilt;
    logic               en;
  } entry_t;

  // A classified item on its way from the front to the back end.
  typedef struct packed {
    logic        is_poll;
    logic [31:0] now_ms;
    entry_t      entry;
  } fq_item_t;

  typedef struct packed {
    logic [14:0] max_rpm;
    logic [15:0] tilt_delay_ms;
    logic [15:0] min_tilt_delay_ms;
    logic        pan_invert;
    logic        tilt_invert;
    logic        pan_axis_on;
    logic        tilt_axis_on;
    logic        enable_active_high;
  } cfg_t;

  // Symmetric clamp of a signed rpm value to +/- lim.
  function automatic logic signed [15:0] clamp_rpm(input logic signed [15:0] v,
                                                   input logic [14:0] lim);
    logic signed [16:0] v17;
    logic signed [16:0] lim17;
    logic signed [16:0] res;
    v17   = {v[15], v};
    lim17 = {2'b00, lim};
    if (v17 > lim17) begin
      res = lim17;
    end else if (v17 < -lim17) begin
      res = -lim17;
    end else begin
      res = v17;
    end
    return res[15:0];
  endfunction

  // Ring index advance with wrap at QUEUE_SLOTS.
  function automatic logic [Q_IDX_W-1:0] ring_next(input logic [Q_IDX_W-1:0] i);
    logic [Q_IDX_W-1:0] res;
    if (i == Q_IDX_W'(QUEUE_SLOTS - 1)) begin
      res = '0;
    end else begin
      res = i + Q_IDX_W'(1);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/tacs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/tacs_front.sv @@
// Front end: accepts items, classifies and clamps them, and queues them for the back end.
`timescale 1ns / 1ps

module tacs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  tacs_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  tacs_pkg::in_item_t  in_item,
  output logic                fq_valid,
  output tacs_pkg::fq_item_t  fq_item,
  input  logic                fq_pop
);

  tacs_pkg::fq_item_t                    slot_r [tacs_pkg::FQ_SLOTS];
  logic [tacs_pkg::FQ_IDX_W-1:0]         wp_r, wp_nxt;
  logic [tacs_pkg::FQ_IDX_W-1:0]         rp_r, rp_nxt;
  logic [tacs_pkg::FQ_CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                  push;
  tacs_pkg::fq_item_t                    cls;

  // Classification: requests become ready-to-store entries with clamped speeds.
  always_comb begin
    cls          = '0;
    cls.now_ms   = in_item.now_ms;
    cls.is_poll  = (in_item.action == tacs_pkg::ACT_POLL);
    case (in_item.action)
      tacs_pkg::ACT_VEL: begin
        cls.entry.kind = tacs_pkg::KIND_VEL;
        cls.entry.pan  = tacs_pkg::clamp_rpm(in_item.pan_speed, cfg.max_rpm);
        cls.entry.tilt = tacs_pkg::clamp_rpm(in_item.tilt_speed, cfg.max_rpm);
      end
      tacs_pkg::ACT_EN: begin
        cls.entry.kind = tacs_pkg::KIND_EN;
        cls.entry.en   = in_item.enable_request;
      end
      tacs_pkg::ACT_STOP: begin
        cls.entry.kind = tacs_pkg::KIND_STOP;
      end
      default: begin
        cls.entry.kind = tacs_pkg::KIND_VEL;
      end
    endcase
  end

  assign in_stall = (cnt_r == tacs_pkg::FQ_CNT_W'(tacs_pkg::FQ_SLOTS));
  assign push     = in_valid && !in_stall;
  assign fq_valid = (cnt_r != '0);
  assign fq_item  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == tacs_pkg::FQ_IDX_W'(tacs_pkg::FQ_SLOTS - 1)) ? '0
             : wp_r + tacs_pkg::FQ_IDX_W'(1);
    end
    if (fq_pop) begin
      rp_nxt = (rp_r == tacs_pkg::FQ_IDX_W'(tacs_pkg::FQ_SLOTS - 1)) ? '0
             : rp_r + tacs_pkg::FQ_IDX_W'(1);
    end
    if (push && !fq_pop) begin
      cnt_nxt = cnt_r + tacs_pkg::FQ_CNT_W'(1);
    end else if (!push && fq_pop) begin
      cnt_nxt = cnt_r - tacs_pkg::FQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule

@@ rtl/core/tacs_back.sv @@
// Back end: command ring with drop-oldest, paced pan/tilt dispatch and the result register.
`timescale 1ns / 1ps

module tacs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tacs_pkg::cfg_t      cfg,
  input  logic                fq_valid,
  input  tacs_pkg::fq_item_t  fq_item,
  output logic                fq_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tacs_pkg::out_item_t out_item
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                          st_r, st_nxt;
  logic [tacs_pkg::Q_IDX_W-1:0]  w_r, w_nxt;
  logic [tacs_pkg::Q_IDX_W-1:0]  r_r, r_nxt;
  logic [31:0]                   drops_r, drops_nxt;
  logic                          busy_r, busy_nxt;
  logic                          second_r, second_nxt;
  logic [31:0]                   due_r, due_nxt;
  tacs_pkg::entry_t              cmd_r, cmd_nxt;
  logic [31:0]                   now_r, now_nxt;
  logic                          out_valid_r, out_valid_nxt;
  tacs_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                          ram_we, ram_re;
  logic [$bits(tacs_pkg::entry_t)-1:0] ram_rdata;
  tacs_pkg::entry_t              rd_entry;

  logic                          out_free;
  logic                          flush;
  logic [tacs_pkg::Q_IDX_W-1:0]  r_base;
  logic [tacs_pkg::Q_IDX_W-1:0]  w_step;
  logic [15:0]                   gap;
  logic [31:0]                   elapsed;
  logic                          emit;
  logic                          emit_ax;
  tacs_pkg::entry_t              emit_cmd;
  logic [tacs_pkg::Q_CNT_W-1:0]  depth_cnt;

  tacs_ram #(
    .WIDTH($bits(tacs_pkg::entry_t)),
    .DEPTH(tacs_pkg::QUEUE_SLOTS)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(w_r),
    .wdata(fq_item.entry),
    .re   (ram_re),
    .raddr(r_r),
    .rdata(ram_rdata)
  );

  assign rd_entry = ram_rdata;

  // Builds one axis action from a command and the current settings.
  function automatic tacs_pkg::out_item_t build_result(input tacs_pkg::entry_t c,
                                                       input logic ax,
                                                       input tacs_pkg::cfg_t k,
                                                       input logic [2:0] dep,
                                                       input logic [31:0] drp);
    tacs_pkg::out_item_t res;
    logic signed [15:0]  rpm;
    logic                inv;
    res       = '0;
    res.axis  = ax;
    res.kind  = c.kind;
    inv       = (ax == tacs_pkg::AXIS_TILT) ? k.tilt_invert : k.pan_invert;
    rpm       = tacs_pkg::clamp_rpm((ax == tacs_pkg::AXIS_TILT) ? c.tilt : c.pan, k.max_rpm);
    if (c.kind == tacs_pkg::KIND_VEL) begin
      res.direction       = rpm[15] ^ inv;
      res.speed_magnitude = rpm[15] ? 15'(-rpm) : rpm[14:0];
    end else if (c.kind == tacs_pkg::KIND_EN) begin
      res.enable_level = k.enable_active_high ? c.en : !c.en;
    end
    res.queue_depth = dep;
    res.drops       = drp;
    return res;
  endfunction

  assign gap      = (cfg.tilt_delay_ms < cfg.min_tilt_delay_ms) ? cfg.min_tilt_delay_ms
                  : cfg.tilt_delay_ms;
  assign out_free = !out_valid_r || !out_stall;
  assign flush    = (fq_item.entry.kind != tacs_pkg::KIND_VEL);
  assign r_base   = flush ? w_r : r_r;
  assign w_step   = tacs_pkg::ring_next(w_r);
  assign elapsed  = fq_item.now_ms - due_r;

  always_comb begin
    st_nxt        = st_r;
    w_nxt         = w_r;
    r_nxt         = r_r;
    drops_nxt     = drops_r;
    busy_nxt      = busy_r;
    second_nxt    = second_r;
    due_nxt       = due_r;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    fq_pop        = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    emit          = 1'b0;
    emit_ax       = tacs_pkg::AXIS_PAN;
    emit_cmd      = cmd_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_RUN: begin
        if (fq_valid && !fq_item.is_poll) begin
          // Request: optional flush and abort, then push with drop-oldest.
          fq_pop = 1'b1;
          ram_we = 1'b1;
          w_nxt  = w_step;
          r_nxt  = r_base;
          if (w_step == r_base) begin
            r_nxt     = tacs_pkg::ring_next(r_base);
            drops_nxt = drops_r + 32'd1;
          end
          if (flush) begin
            busy_nxt   = 1'b0;
            second_nxt = 1'b0;
            due_nxt    = '0;
          end
        end else if (fq_valid && out_free) begin
          fq_pop = 1'b1;
          if (!busy_r) begin
            if (r_r != w_r) begin
              ram_re  = 1'b1;
              now_nxt = fq_item.now_ms;
              st_nxt  = ST_READ;
            end
          end else if (!elapsed[31]) begin
            emit     = 1'b1;
            emit_ax  = second_r;
            emit_cmd = cmd_r;
            if (!second_r) begin
              second_nxt = 1'b1;
              due_nxt    = fq_item.now_ms + 32'(gap);
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
      end
      ST_READ: begin
        // Fresh pop: the pan action is always due at once.
        cmd_nxt    = rd_entry;
        r_nxt      = tacs_pkg::ring_next(r_r);
        busy_nxt   = 1'b1;
        second_nxt = 1'b1;
        due_nxt    = now_r + 32'(gap);
        emit       = 1'b1;
        emit_ax    = tacs_pkg::AXIS_PAN;
        emit_cmd   = rd_entry;
        st_nxt     = ST_RUN;
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase

    if (w_nxt >= r_nxt) begin
      depth_cnt = tacs_pkg::Q_CNT_W'(w_nxt) - tacs_pkg::Q_CNT_W'(r_nxt);
    end else begin
      depth_cnt = tacs_pkg::Q_CNT_W'(tacs_pkg::QUEUE_SLOTS) + tacs_pkg::Q_CNT_W'(w_nxt)
                - tacs_pkg::Q_CNT_W'(r_nxt);
    end

    if (emit && ((emit_ax == tacs_pkg::AXIS_TILT) ? cfg.tilt_axis_on : cfg.pan_axis_on)
        && (emit_cmd.kind <= tacs_pkg::KIND_STOP)) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = build_result(emit_cmd, emit_ax, cfg, 3'(depth_cnt), drops_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      w_r         <= '0;
      r_r         <= '0;
      drops_r     <= '0;
      busy_r      <= 1'b0;
      second_r    <= 1'b0;
      due_r       <= '0;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      w_r         <= w_nxt;
      r_r         <= r_nxt;
      drops_r     <= drops_nxt;
      busy_r      <= busy_nxt;
      second_r    <= second_nxt;
      due_r       <= due_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/two_axis_command_sequencer.sv @@
// Top level of the two-axis command sequencer: configuration registers and the front/back pair.
`timescale 1ns / 1ps

// The sequencer takes velocity, enable and stop requests plus poll items that carry the
// current millisecond time, and turns queued commands into paced pan and tilt actions.
// Requests go into a ring of QUEUE_SLOTS slots that holds at most QUEUE_SLOTS-1 commands;
// when it is full the oldest command is dropped and counted. Enable and stop flush the
// ring and abort the command in progress before they queue themselves. A poll on an idle
// block pops the oldest command and emits its pan action at once; a later poll emits the
// tilt action once max(tilt_delay_ms, min_tilt_delay_ms) milliseconds have passed, using a
// wrapping signed compare. A disabled axis still advances the sequence but emits nothing.
// Timing: an accepted item first passes a two-entry input queue, so in_stall rises only
// when that queue is full. In the back end a request, or a poll that emits from the
// command in progress (or finds nothing to do), is handled in the RUN state alone. A poll
// that pops a command also passes the READ state, since the ring lives in a RAM with a
// registered read port. A poll is also held while the output register still carries a
// result that has not been transferred. Results leave through that register, and at
// most one result follows from each poll. Configuration may be written only while
// the block is idle; cfg_ready is always high.

module two_axis_command_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tacs_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tacs_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tacs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tacs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tacs_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               fq_valid;
  logic               fq_pop;
  tacs_pkg::fq_item_t fq_item;

  // Configuration registers. Writes to indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tacs_pkg::REG_MAX_RPM:      cfg_nxt.max_rpm            = cfg_data[14:0];
        tacs_pkg::REG_AXIS_GAP:     cfg_nxt.tilt_delay_ms      = cfg_data[15:0];
        tacs_pkg::REG_MIN_AXIS_GAP: cfg_nxt.min_tilt_delay_ms  = cfg_data[15:0];
        tacs_pkg::REG_PAN_INVERT:   cfg_nxt.pan_invert         = cfg_data[0];
        tacs_pkg::REG_TILT_INVERT:  cfg_nxt.tilt_invert        = cfg_data[0];
        tacs_pkg::REG_PAN_AXIS_ON:  cfg_nxt.pan_axis_on        = cfg_data[0];
        tacs_pkg::REG_TILT_AXIS_ON: cfg_nxt.tilt_axis_on       = cfg_data[0];
        tacs_pkg::REG_EN_ACT_HIGH:  cfg_nxt.enable_active_high = cfg_data[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_rpm            <= tacs_pkg::RST_MAX_RPM;
      cfg_r.tilt_delay_ms      <= tacs_pkg::RST_AXIS_GAP;
      cfg_r.min_tilt_delay_ms  <= tacs_pkg::RST_MIN_AXIS_GAP;
      cfg_r.pan_invert         <= 1'b0;
      cfg_r.tilt_invert        <= 1'b0;
      cfg_r.pan_axis_on        <= 1'b1;
      cfg_r.tilt_axis_on       <= 1'b1;
      cfg_r.enable_active_high <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end accepts and classifies; its queue decouples it from the back end.
  tacs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item (in_item),
    .fq_valid(fq_valid),
    .fq_item (fq_item),
    .fq_pop  (fq_pop)
  );

  // The back end owns the command ring, the dispatch pacing and the result register.
  tacs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fq_valid (fq_valid),
    .fq_item  (fq_item),
    .fq_pop   (fq_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

@@ rtl/core/tacs_checker.sv @@
// Port-level checker for the two-axis command sequencer and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tacs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tacs_pkg::out_item_t out_item
);

  logic out_held;
  logic non_vel;
  logic non_en;
  logic speed_clear;
  logic kind_ok;

  assign out_held    = out_valid && out_stall;
  assign non_vel     = out_valid && (out_item.kind != tacs_pkg::KIND_VEL);
  assign non_en      = out_valid && (out_item.kind != tacs_pkg::KIND_EN);
  assign speed_clear = (out_item.speed_magnitude == 15'd0) && !out_item.direction;
  assign kind_ok     = (out_item.kind == tacs_pkg::KIND_VEL)
                    || (out_item.kind == tacs_pkg::KIND_EN)
                    || (out_item.kind == tacs_pkg::KIND_STOP);

  `ASSERT_NEXT_ALWAYS(a_reset_no_result, !rst_n, !out_valid, "result valid right after reset")
  `ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_item), "stalled result changed")
  `ASSERT_IMPLY(a_vel_only_speed, non_vel, speed_clear, "speed fields set on a non-velocity result")
  `ASSERT_IMPLY(a_en_only_level, non_en, !out_item.enable_level, "enable level on a non-enable result")
  `ASSERT_IMPLY(a_kind_known, out_valid, kind_ok, "result with an unknown kind")

endmodule

bind two_axis_command_sequencer tacs_checker u_tacs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
